>>> rtl/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg
// Types, codes and the character map shared by the stream decoder modules.
// ----------------------------------------------------------------------------
package b64d_pkg;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_INVALID = 2'd1;
  localparam logic [1:0] STATUS_BAD_LEN = 2'd2;

  localparam logic [1:0] PHASE_FIRST  = 2'd0;
  localparam logic [1:0] PHASE_SECOND = 2'd1;
  localparam logic [1:0] PHASE_THIRD  = 2'd2;
  localparam logic [1:0] PHASE_FOURTH = 2'd3;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_string;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       data_valid;
    logic       last_of_run;
    logic       string_done;
    logic [1:0] status;
  } out_res_t;

  // One request for the back end: up to three bytes, packed to the front.
  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [1:0] count;      // results to emit, 1 to 3
    logic       data_valid; // 0 for a closing result that carries no byte
    logic       done;
    logic [1:0] status;
  } rec_t;

  // Bit 6 set: not in the alphabet.
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h40;
    if (c inside {[8'h41:8'h5A]}) begin
      d = c - 8'h41;
    end else if (c inside {[8'h61:8'h7A]}) begin
      d = c - 8'h47;
    end else if (c inside {[8'h30:8'h39]}) begin
      d = c + 8'h04;
    end else if (c == 8'h2B) begin
      d = 8'd62;
    end else if (c == 8'h2F) begin
      d = 8'd63;
    end
    return d[6:0];
  endfunction

endpackage

>>> rtl/b64d_front.sv
// ----------------------------------------------------------------------------
// b64d_front
// Maps characters to sextets, tracks the group and the error, and builds one
// request per character that completes a group or ends the string.
// ----------------------------------------------------------------------------
module b64d_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  b64d_pkg::in_item_t item,
  output logic               rec_push,
  output b64d_pkg::rec_t     rec
);
  import b64d_pkg::*;

  logic [1:0]  phase_r, phase_nxt;
  logic [17:0] acc_r, acc_nxt;
  logic        tp_r, tp_nxt;
  logic        err_r, err_nxt;

  logic [6:0]  sx;
  logic [5:0]  val;
  logic        is_pad, ok, err_now, emit;
  logic [7:0]  b0, b1, b2;

  always_comb begin
    sx      = sextet_of(item.char_code);
    is_pad  = (item.char_code == PAD_CHAR);
    ok      = !sx[6] || (is_pad && phase_r[1]);
    val     = sx[6] ? 6'd0 : sx[5:0];
    err_now = err_r || !ok;
    emit    = (phase_r == PHASE_FOURTH) && !err_now;
    b0      = acc_r[17:10];
    b1      = acc_r[9:2];
    b2      = {acc_r[1:0], val};

    rec            = '0;
    rec.done       = item.end_of_string;
    rec.data_valid = emit;
    if (emit) begin
      rec.byte0 = b0;
      rec.byte1 = tp_r ? b2 : b1;
      rec.byte2 = b2;
      rec.count = 2'd1 + {1'b0, !tp_r} + {1'b0, !is_pad};
    end else begin
      rec.count = 2'd1;
    end
    if (phase_r != PHASE_FOURTH) begin
      rec.status = STATUS_BAD_LEN;
    end else if (err_now) begin
      rec.status = STATUS_INVALID;
    end else begin
      rec.status = STATUS_OK;
    end
    rec_push = accept && (emit || item.end_of_string);

    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    tp_nxt    = tp_r;
    err_nxt   = err_r;
    if (accept) begin
      phase_nxt = phase_r + 2'd1;
      err_nxt   = err_now;
      case (phase_r)
        PHASE_FIRST: begin
          acc_nxt = {val, 12'd0};
          tp_nxt  = 1'b0;
        end
        PHASE_SECOND: acc_nxt[11:6] = val;
        PHASE_THIRD: begin
          acc_nxt[5:0] = val;
          tp_nxt       = is_pad;
        end
        default: ;
      endcase
      // drop all group state once the string closes
      if (item.end_of_string) begin
        phase_nxt = PHASE_FIRST;
        acc_nxt   = '0;
        tp_nxt    = 1'b0;
        err_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PHASE_FIRST;
      acc_r   <= '0;
      tp_r    <= 1'b0;
      err_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      tp_r    <= tp_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

>>> rtl/b64d_queue.sv
// ----------------------------------------------------------------------------
// b64d_queue
// Short first-in first-out queue of requests between front and back end.
// ----------------------------------------------------------------------------
module b64d_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  b64d_pkg::rec_t wdata,
  input  logic           pop,
  output b64d_pkg::rec_t rdata,
  output logic           full,
  output logic           empty
);
  import b64d_pkg::*;

  rec_t            mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_AW:0]   cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  always_comb begin
    full       = (cnt_r == (Q_AW+1)'(Q_DEPTH));
    empty      = (cnt_r == '0);
    do_push    = push && !full;
    do_pop     = pop && !empty;
    rdata      = mem_r[rd_ptr_r];
    wr_ptr_nxt = do_push ? Q_AW'((Q_AW+1)'(wr_ptr_r) + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? Q_AW'((Q_AW+1)'(rd_ptr_r) + 1'b1) : rd_ptr_r;
    cnt_nxt    = cnt_r + (Q_AW+1)'(do_push) - (Q_AW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

>>> rtl/b64d_back.sv
// ----------------------------------------------------------------------------
// b64d_back
// Holds the current request and steps through its results, one per pop.
// ----------------------------------------------------------------------------
module b64d_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  b64d_pkg::rec_t      q_rdata,
  output logic                q_pop,
  output logic                out_empty,
  input  logic                out_pop,
  output b64d_pkg::out_res_t  out_res
);
  import b64d_pkg::*;

  rec_t       cur_r, cur_nxt;
  logic       vld_r, vld_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       is_last, take;

  always_comb begin
    is_last = (idx_r == cur_r.count - 2'd1);
    out_empty = !vld_r;

    out_res = '0;
    case (idx_r)
      2'd0:    out_res.data_byte = cur_r.byte0;
      2'd1:    out_res.data_byte = cur_r.byte1;
      default: out_res.data_byte = cur_r.byte2;
    endcase
    out_res.data_valid  = cur_r.data_valid;
    out_res.last_of_run = is_last;
    out_res.string_done = is_last && cur_r.done;
    out_res.status      = (is_last && cur_r.done) ? cur_r.status : STATUS_OK;

    // load the next request when idle or as the last result leaves
    take    = !vld_r || (out_pop && is_last);
    q_pop   = take && !q_empty;
    cur_nxt = q_pop ? q_rdata : cur_r;
    vld_nxt = take ? !q_empty : vld_r;
    idx_nxt = take ? 2'd0 : (out_pop ? idx_r + 2'd1 : idx_r);
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= 2'd0;
    end else begin
      vld_r <= vld_nxt;
      idx_r <= idx_nxt;
    end
  end

endmodule

>>> rtl/base64_stream_decoder.sv
// ----------------------------------------------------------------------------
// base64_stream_decoder
// Base64 text decoder, one character in per cycle, bytes out as a queue.
// ----------------------------------------------------------------------------
// Input: one character per request with an end-of-string flag, taken when
// in_push is high and in_full low. Results: read the oldest result on
// out_res while out_empty is low; out_pop takes it.
// Each fourth character of a group gives one to three byte results; the
// last character of a string gives the closing result with the status
// (0 ok, 1 invalid character, 2 length not a multiple of four). Bytes of a
// string whose status is not zero are to be discarded by the receiver.
// A result passes the request queue and then the result register.
// Throughput: one character per cycle; results leave at up to one per cycle,
// so four characters (three results) keep pace. The four-entry request queue
// between the character front end and the result back end sets how far the
// input runs ahead when the receiver stalls; in_full rises once it fills.
// Reset clears the group state, the queue and the result valid flag.
// ----------------------------------------------------------------------------
module base64_stream_decoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  b64d_pkg::in_item_t in_item,
  output logic               out_empty,
  input  logic               out_pop,
  output b64d_pkg::out_res_t out_res
);
  import b64d_pkg::*;

  logic rec_push, q_pop, q_empty, q_full, accept;
  rec_t rec, q_rdata;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  b64d_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .item     (in_item),
    .rec_push (rec_push),
    .rec      (rec)
  );

  b64d_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (rec_push),
    .wdata (rec),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  b64d_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_res   (out_res)
  );

endmodule

>>> rtl/b64d_checker.sv
// ----------------------------------------------------------------------------
// b64d_checker
// Port-level checks on the decoder's result channel.
// ----------------------------------------------------------------------------
module b64d_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_empty,
  input logic               out_pop,
  input b64d_pkg::out_res_t out_res
);
  import b64d_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_res.string_done) |-> out_res.last_of_run)
    else $error("string closed before the last result of its request");

  a_status_on_close: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_res.string_done) |-> (out_res.status == STATUS_OK))
    else $error("status shown on a result that does not close a string");

  a_empty_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_res.data_valid) |-> (out_res.string_done && out_res.data_byte == 8'd0))
    else $error("result without a byte does not close a string");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_res)))
    else $error("waiting result changed while stalled");

endmodule

bind base64_stream_decoder b64d_checker u_b64d_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_res   (out_res)
);
